FILE: hw/rtl/short_long_address_table_core_assert.svh
// Assertion macros for the short/long address table.
`ifndef SHORT_LONG_ADDRESS_TABLE_CORE_ASSERT_SVH
`define SHORT_LONG_ADDRESS_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SLAT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define SLAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/slat_pkg.sv
// Shared types and constants for the short/long address table.
package slat_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int OP_W          = 2;
   localparam int LONG_W        = 64;
   localparam int SHORT_W       = 16;
   localparam int INDEX_W       = 4;
   localparam int ENTRY_W       = LONG_W + SHORT_W;

   typedef enum logic [OP_W-1:0] {
      OP_ADD        = 2'd0,
      OP_FIND_LONG  = 2'd1,
      OP_FIND_SHORT = 2'd2,
      OP_CLEAR      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 hit;
      logic                 stored;
      logic                 table_full;
      logic [INDEX_W-1:0]   entry_index;
      logic [LONG_W-1:0]    found_long_address;
      logic [SHORT_W-1:0]   found_short_address;
   } result_type;

endpackage

FILE: hw/rtl/slat_if.sv
// Request and response channel interfaces for the short/long address table.
interface slat_req_if;
   import slat_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [LONG_W-1:0]   long_address;
   logic [SHORT_W-1:0]  short_address;

   modport source (output valid, operation, long_address, short_address, input ready);
   modport sink   (input valid, operation, long_address, short_address, output ready);
endinterface

interface slat_rsp_if;
   import slat_pkg::*;

   logic                valid;
   logic                ready;
   logic                hit;
   logic                stored;
   logic                table_full;
   logic [INDEX_W-1:0]  entry_index;
   logic [LONG_W-1:0]   found_long_address;
   logic [SHORT_W-1:0]  found_short_address;

   modport source (output valid, hit, stored, table_full, entry_index, found_long_address,
                   found_short_address, input ready);
   modport sink   (input valid, hit, stored, table_full, entry_index, found_long_address,
                   found_short_address, output ready);
endinterface

FILE: hw/rtl/slat_ram.sv
// Generic single-port-write, registered-read RAM.
module slat_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/slat_ctrl.sv
// Scan sequencer: valid bits, table RAM access and result assembly.
module slat_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [slat_pkg::OP_W-1:0]    req_operation,
   input  logic [slat_pkg::LONG_W-1:0]  req_long_address,
   input  logic [slat_pkg::SHORT_W-1:0] req_short_address,
   output logic                         res_valid,
   input  logic                         res_take,
   output slat_pkg::result_type         res_data
);
   import slat_pkg::*;

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [LONG_W-1:0]      long_ff, long_in;
   logic [SHORT_W-1:0]     short_ff, short_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       scan_cnt_ff, scan_cnt_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]       chk_idx_ff, chk_idx_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       found_idx_ff, found_idx_in;
   logic [LONG_W-1:0]      found_long_ff, found_long_in;
   logic [SHORT_W-1:0]     found_short_ff, found_short_in;
   logic                   free_ff, free_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;

   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [ENTRY_W-1:0]     ram_rd_data;
   logic [LONG_W-1:0]      ent_long;
   logic [SHORT_W-1:0]     ent_short;
   logic                   ent_valid;
   logic                   key_match;
   logic                   scan_end;

   slat_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (free_idx_ff),
      .wr_data ({long_ff, short_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_cnt_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign ent_long  = ram_rd_data[ENTRY_W-1:SHORT_W];
   assign ent_short = ram_rd_data[SHORT_W-1:0];
   assign ent_valid = valid_ff[chk_idx_ff];
   assign scan_end  = (scan_cnt_ff == CNT_W'(TABLE_ENTRIES));

   always_comb begin
      unique case (op_ff)
         OP_ADD:        key_match = (ent_long == long_ff) && (ent_short == short_ff);
         OP_FIND_LONG:  key_match = (ent_long == long_ff);
         OP_FIND_SHORT: key_match = (ent_short == short_ff);
         default:       key_match = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         chk_vld_ff <= chk_vld_in;
      end
      op_ff          <= op_in;
      long_ff        <= long_in;
      short_ff       <= short_in;
      scan_cnt_ff    <= scan_cnt_in;
      chk_idx_ff     <= chk_idx_in;
      found_ff       <= found_in;
      found_idx_ff   <= found_idx_in;
      found_long_ff  <= found_long_in;
      found_short_ff <= found_short_in;
      free_ff        <= free_in;
      free_idx_ff    <= free_idx_in;
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      long_in        = long_ff;
      short_in       = short_ff;
      valid_in       = valid_ff;
      scan_cnt_in    = scan_cnt_ff;
      chk_vld_in     = 1'b0;
      chk_idx_in     = chk_idx_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_long_in  = found_long_ff;
      found_short_in = found_short_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      req_ready      = 1'b0;
      ram_rd_en      = 1'b0;
      ram_wr_en      = 1'b0;
      res_valid      = 1'b0;
      res_data       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in       = op_type'(req_operation);
               long_in     = req_long_address;
               short_in    = req_short_address;
               scan_cnt_in = '0;
               found_in    = 1'b0;
               free_in     = 1'b0;
               if (op_type'(req_operation) == OP_CLEAR) begin
                  valid_in = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (!scan_end) begin
               ram_rd_en   = 1'b1;
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
               chk_vld_in  = 1'b1;
               chk_idx_in  = scan_cnt_ff[IDX_W-1:0];
            end
            if (chk_vld_ff) begin
               if (ent_valid && key_match && !found_ff) begin
                  found_in       = 1'b1;
                  found_idx_in   = chk_idx_ff;
                  found_long_in  = ent_long;
                  found_short_in = ent_short;
               end
               if (!ent_valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
            end
            if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            priority if (op_ff == OP_CLEAR) begin
               res_data = '0;
            end else if (found_ff) begin
               res_data.hit                 = 1'b1;
               res_data.entry_index         = INDEX_W'(found_idx_ff);
               res_data.found_long_address  = found_long_ff;
               res_data.found_short_address = found_short_ff;
            end else if (op_ff == OP_ADD && free_ff) begin
               res_data.stored      = 1'b1;
               res_data.entry_index = INDEX_W'(free_idx_ff);
            end else if (op_ff == OP_ADD) begin
               res_data.table_full = 1'b1;
            end else begin
               res_data = '0;
            end
            if (res_take) begin
               if (op_ff == OP_ADD && !found_ff && free_ff) begin
                  ram_wr_en              = 1'b1;
                  valid_in[free_idx_ff]  = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: hw/rtl/short_long_address_table_core.sv
// Top level of the short/long address table with response register and checks.
`include "short_long_address_table_core_assert.svh"

// Table of TABLE_ENTRIES pairs of 64-bit long and 16-bit short addresses held in
// one synchronous RAM. Operations: add pair, find by long address, find by short
// address, clear. Each request transaction yields exactly one response
// transaction. Add, find by long and find by short read every entry in turn
// through the single RAM read port, one entry per cycle; an add that stores
// writes the RAM in its last cycle. Clear resets the valid flip-flops. The
// response sits in an output register, so a new request is taken while a
// response waits; a response finished while the register is still full holds
// the sequencer until it drains.
module short_long_address_table_core (
   input  logic       clock,
   input  logic       reset,
   slat_req_if.sink   req_chan,
   slat_rsp_if.source rsp_chan
);
   import slat_pkg::*;

   logic       res_valid;
   logic       res_take;
   result_type res_data;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   slat_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_chan.valid),
      .req_ready         (req_chan.ready),
      .req_operation     (req_chan.operation),
      .req_long_address  (req_chan.long_address),
      .req_short_address (req_chan.short_address),
      .res_valid         (res_valid),
      .res_take          (res_take),
      .res_data          (res_data)
   );

   assign res_take = res_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.hit                 = rsp_data_ff.hit;
   assign rsp_chan.stored              = rsp_data_ff.stored;
   assign rsp_chan.table_full          = rsp_data_ff.table_full;
   assign rsp_chan.entry_index         = rsp_data_ff.entry_index;
   assign rsp_chan.found_long_address  = rsp_data_ff.found_long_address;
   assign rsp_chan.found_short_address = rsp_data_ff.found_short_address;

   `SLAT_ASSERT_SAME(a_one_outcome, clock, reset, rsp_valid_ff,
      $onehot0({rsp_data_ff.hit, rsp_data_ff.stored, rsp_data_ff.table_full}),
      "more than one outcome flag in a response")
   `SLAT_ASSERT_SAME(a_miss_no_addr, clock, reset, rsp_valid_ff && !rsp_data_ff.hit,
      rsp_data_ff.found_long_address == '0 && rsp_data_ff.found_short_address == '0,
      "addresses reported without a match")
   `SLAT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_chan.valid && req_chan.ready,
      !req_chan.ready, "request taken while a transaction is in progress")

endmodule
